>>> src/crc16_frame_receiver_core_macros.svh
// assertion macros for the crc16 frame receiver
// no dependencies; included by modules that carry assertions
`ifndef CRC16_FRAME_RECEIVER_CORE_MACROS_SVH
`define CRC16_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CRCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crcfr assertion failed");

// next-cycle implication, disabled while in reset
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crcfr assertion failed");

`endif

>>> src/crcfr_pkg.sv
// types, constants and the bytewise crc16 update for the frame receiver
// no dependencies
package crcfr_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'hA5;
	localparam logic [7:0]  HDR_SECOND = 8'h5A;
	localparam logic [7:0]  TAIL_BYTE  = 8'hFF;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	typedef enum logic [2:0] {
		PH_WAIT_A5   = 3'd0,
		PH_WAIT_5A   = 3'd1,
		PH_LENGTH    = 3'd2,
		PH_COMMAND   = 3'd3,
		PH_PAYLOAD   = 3'd4,
		PH_CRC_HIGH  = 3'd5,
		PH_CRC_LOW   = 3'd6,
		PH_TAIL      = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_ACCEPT  = 3'd2,
		EV_CRCERR  = 3'd3,
		EV_TAILERR = 3'd4
	} event_t;

	// reflected crc16, lsb first, eight fixed shift/xor steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/crc16_frame_receiver_core.sv
// the result of an accepted byte is registered and shows on m_axis in the next cycle
// throughput: one byte per cycle while m_axis is not stalled; the parser state and the
//   bytewise crc update (eight unrolled xor steps) are combinational, so bytes may follow back to back
// one result register: input stalls while a result waits with m_axis_tready low
// reset: arst_n asynchronous, active low; parser waits for A5, crc = FFFF, held bytes zero
// depends on crcfr_pkg and crc16_frame_receiver_core_macros.svh
`include "crc16_frame_receiver_core_macros.svh"

module crc16_frame_receiver_core
	import crcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// receive byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                                    // [23:16] frame_command, [31:24] frame_length
	output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

	// parser state
	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_high_q, crc_high_d;

	// result of the byte being accepted
	event_t      ev_d;
	logic [7:0]  pbyte_d, pidx_d;

	// result register
	logic        valid_s1;
	event_t      ev_s1;
	logic [7:0]  pbyte_s1, pidx_s1, command_s1, length_s1;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] crc_fed;
	logic [15:0] crc_restart;
	logic [7:0]  count_inc;

	// a new byte enters whenever the result slot is free or being emptied
	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	assign crc_fed     = crc_feed(crc_q, b);
	assign crc_restart = crc_feed(CRC_INIT, b);
	assign count_inc   = count_q + 8'd1;

	// next state and result for one byte
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		length_d   = length_q;
		command_d  = command_q;
		crc_d      = crc_q;
		crc_high_d = crc_high_q;
		ev_d       = EV_NONE;
		pbyte_d    = 8'd0;
		pidx_d     = 8'd0;
		case (phase_q)
			PH_WAIT_A5: begin
				if (b == HDR_FIRST) begin
					phase_d = PH_WAIT_5A;
					count_d = 8'd0;
					crc_d   = crc_restart;
				end
			end
			PH_WAIT_5A: begin
				if (b == HDR_SECOND) begin
					crc_d   = crc_fed;
					phase_d = PH_LENGTH;
				end else if (b == HDR_FIRST) begin
					phase_d = PH_WAIT_5A;
					count_d = 8'd0;
					crc_d   = crc_restart;
				end else begin
					phase_d = PH_WAIT_A5;
				end
			end
			PH_LENGTH: begin
				length_d = b;
				crc_d    = crc_fed;
				phase_d  = PH_COMMAND;
			end
			PH_COMMAND: begin
				command_d = b;
				crc_d     = crc_fed;
				count_d   = 8'd0;
				// empty payload skips straight to the crc bytes
				phase_d   = (length_q == 8'd0) ? PH_CRC_HIGH : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				ev_d    = EV_PAYLOAD;
				pbyte_d = b;
				pidx_d  = count_q;
				crc_d   = crc_fed;
				count_d = count_inc;
				if (count_inc == length_q) begin
					phase_d = PH_CRC_HIGH;
				end
			end
			PH_CRC_HIGH: begin
				crc_high_d = b;
				phase_d    = PH_CRC_LOW;
			end
			PH_CRC_LOW: begin
				if ({crc_high_q, b} == crc_q) begin
					phase_d = PH_TAIL;
				end else begin
					ev_d = EV_CRCERR;
					// mismatch byte may itself open a new header
					if (b == HDR_FIRST) begin
						phase_d = PH_WAIT_5A;
						count_d = 8'd0;
						crc_d   = crc_restart;
					end else begin
						phase_d = PH_WAIT_A5;
					end
				end
			end
			PH_TAIL: begin
				if (b == TAIL_BYTE) begin
					ev_d    = EV_ACCEPT;
					phase_d = PH_WAIT_A5;
				end else begin
					ev_d = EV_TAILERR;
					if (b == HDR_FIRST) begin
						phase_d = PH_WAIT_5A;
						count_d = 8'd0;
						crc_d   = crc_restart;
					end else begin
						phase_d = PH_WAIT_A5;
					end
				end
			end
			default: begin
				phase_d = PH_WAIT_A5;
			end
		endcase
	end

	// parser state registers, updated only on an accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_A5;
			count_q    <= 8'd0;
			length_q   <= 8'd0;
			command_q  <= 8'd0;
			crc_q      <= CRC_INIT;
			crc_high_q <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			length_q   <= length_d;
			command_q  <= command_d;
			crc_q      <= crc_d;
			crc_high_q <= crc_high_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	// result payload, snapshot of held bytes after this byte
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1      <= ev_d;
			pbyte_s1   <= pbyte_d;
			pidx_s1    <= pidx_d;
			command_s1 <= command_d;
			length_s1  <= length_d;
		end
	end

	assign m_axis_tvalid = valid_s1;
	assign m_axis_tdata  = {length_s1, command_s1, pidx_s1, pbyte_s1};
	assign m_axis_tuser  = ev_s1;

	// a payload byte always reports a payload event next cycle
	`CRCFR_ASSERT_NEXT(a_payload_event, clk, arst_n,
		accept && phase_q == PH_PAYLOAD, m_axis_tvalid && m_axis_tuser == EV_PAYLOAD)
	// crc high byte is always followed by the crc low phase
	`CRCFR_ASSERT_NEXT(a_crc_high_to_low, clk, arst_n,
		accept && phase_q == PH_CRC_HIGH, phase_q == PH_CRC_LOW)
	// a good tail closes the frame and returns to header search
	`CRCFR_ASSERT_NEXT(a_tail_accept, clk, arst_n,
		accept && phase_q == PH_TAIL && b == TAIL_BYTE,
		phase_q == PH_WAIT_A5 && m_axis_tuser == EV_ACCEPT)
	// non-payload results carry zero byte and index
	`CRCFR_ASSERT_SAME(a_idle_fields_zero, clk, arst_n,
		m_axis_tvalid && m_axis_tuser != EV_PAYLOAD, m_axis_tdata[15:0] == 16'd0)

endmodule
